[src/twf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twf_pkg
// Shared types and constants for the triangle wave finder.
// ----------------------------------------------------------------------------
package twf_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned XW      = 12;
  localparam int unsigned CountW  = 6;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t              sample;
    logic [SampleW-1:0]   threshold;
    logic                 last_sample;
  } twf_in_t;

  typedef struct packed {
    logic [XW-1:0]        left_x;
    sample_t              left_y;
    logic [XW-1:0]        peak_x;
    sample_t              peak_y;
    logic [XW-1:0]        right_x;
    sample_t              right_y;
    logic                 is_count;
    logic [CountW-1:0]    found_count;
    logic                 last;
  } twf_out_t;

  // flags from the shared compare unit, a versus b
  typedef struct packed {
    logic gt;
    logic ge;
    logic ge_th;
  } cmp_t;

  typedef enum logic [1:0] {
    PH_FLAT,
    PH_RISE,
    PH_FALL
  } phase_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL_A,
    ST_EVAL_B,
    ST_EVAL_C,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_EMIT,
    ST_COUNT
  } state_e;

endpackage
`default_nettype wire

[src/twf_diff_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twf_diff_unit
// Shared signed subtract and compare: a - b against zero and the threshold.
// ----------------------------------------------------------------------------
module twf_diff_unit import twf_pkg::*; (
  input  sample_t            a_i,
  input  sample_t            b_i,
  input  logic [SampleW-1:0] th_i,
  output cmp_t               cmp_o
);

  logic signed [SampleW:0]   diff;
  logic signed [SampleW+1:0] diff_x;
  logic signed [SampleW+1:0] th_x;

  assign diff   = $signed({a_i[SampleW-1], a_i}) - $signed({b_i[SampleW-1], b_i});
  assign diff_x = {diff[SampleW], diff};
  assign th_x   = {2'b00, th_i};

  assign cmp_o.gt    = !diff[SampleW] && (diff != '0);
  assign cmp_o.ge    = !diff[SampleW];
  assign cmp_o.ge_th = (diff_x >= th_x);

endmodule
`default_nettype wire

[src/twf_sample_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twf_sample_mem
// Sample buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module twf_sample_mem import twf_pkg::*; #(
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  sample_t                  wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output sample_t                  rd_data_o
);

  sample_t mem_q [Depth];
  sample_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

[src/triangle_wave_finder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_wave_finder_core
// Buffers a run of signed samples, then scans it for rise and fall triangles.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o / in_i) takes one sample word per
//   cycle while loading; the word with last_sample set also latches the
//   threshold and starts the scan. samples beyond BUFFER_DEPTH are dropped.
//   output channel (out_valid_o / out_ready_i / out_o) gives one word per
//   triangle found, then a count word with is_count and last set.
// timing
//   loading: in_ready_o high throughout. scan: each buffer entry takes a
//   memory read, then one to three passes through the single shared
//   subtract/compare unit; each step of each backward base walk adds a
//   memory read and a compare, and each emitted word an emit step.
//   in_ready_o stays low from the last sample until the count word is
//   loaded into the output register.
// reset
//   asynchronous, clears the sequencer, fill count and output valid; buffer
//   contents are not cleared and need no clearing pass.
// stall
//   the output register holds its word until taken; the scan waits at the
//   next word to emit while the previous one is still pending.
// ----------------------------------------------------------------------------
module triangle_wave_finder_core import twf_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH  = 4096,
  parameter int unsigned MAX_TRIANGLES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  twf_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output twf_out_t out_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TW = $clog2(MAX_TRIANGLES + 1);

  // sequencer and control
  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [TW-1:0] tri_q, tri_d;
  logic          below_q, below_d;
  logic          out_valid_q, out_valid_d;

  // scan datapath
  logic [SampleW-1:0] th_q, th_d;
  logic [AW-1:0]      left_x_q, left_x_d, peak_x_q, peak_x_d, right_x_q, right_x_d;
  sample_t            left_y_q, left_y_d, peak_y_q, peak_y_d, right_y_q, right_y_d;
  sample_t            cur_y_q, cur_y_d;
  logic               drop_ge_q, drop_ge_d;
  logic [AW-1:0]      walk_q, walk_d;
  sample_t            prev_q, prev_d;
  logic [AW-1:0]      base_x_q, base_x_d;
  sample_t            base_y_q, base_y_d;
  twf_out_t           out_q, out_d;

  // memory and shared unit
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  sample_t       rd_data;
  sample_t       op_a, op_b;
  cmp_t          cmp;

  sample_t       cy;
  logic [AW-1:0] cx;

  twf_sample_mem #(
    .Depth (BUFFER_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[AW-1:0]),
    .wr_data_i (in_i.sample),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  twf_diff_unit u_diff (
    .a_i   (op_a),
    .b_i   (op_b),
    .th_i  (th_q),
    .cmp_o (cmp)
  );

  // current sample: fresh from memory in the first eval step, held after
  assign cy = (state_q == ST_EVAL_A) ? rd_data : cur_y_q;
  assign cx = idx_q[AW-1:0];

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // operand select for the shared unit
  always_comb begin
    unique case (state_q)
      ST_EVAL_A: begin
        unique case (phase_q)
          PH_RISE: begin
            op_a = peak_y_q;
            op_b = cy;
          end
          PH_FALL: begin
            op_a = cy;
            op_b = right_y_q;
          end
          default: begin
            op_a = cy;
            op_b = left_y_q;
          end
        endcase
      end
      ST_EVAL_B: begin
        op_a = cur_y_q;
        op_b = left_y_q;
      end
      ST_EVAL_C: begin
        op_a = peak_y_q;
        op_b = left_y_q;
      end
      ST_WALK_EV: begin
        if (below_q) begin
          op_a = rd_data;
          op_b = prev_q;
        end else begin
          op_a = peak_y_q;
          op_b = rd_data;
        end
      end
      default: begin
        op_a = cy;
        op_b = left_y_q;
      end
    endcase
  end

  // next state and datapath updates
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    tri_d       = tri_q;
    below_d     = below_q;
    out_valid_d = out_valid_q && !out_ready_i;
    th_d        = th_q;
    left_x_d    = left_x_q;
    left_y_d    = left_y_q;
    peak_x_d    = peak_x_q;
    peak_y_d    = peak_y_q;
    right_x_d   = right_x_q;
    right_y_d   = right_y_q;
    cur_y_d     = cur_y_q;
    drop_ge_d   = drop_ge_q;
    walk_d      = walk_q;
    prev_d      = prev_q;
    base_x_d    = base_x_q;
    base_y_d    = base_y_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cx;

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (fill_q < CW'(BUFFER_DEPTH)) begin
            wr_en  = 1'b1;
            fill_d = fill_q + CW'(1);
          end
          if (in_i.last_sample) begin
            th_d    = in_i.threshold;
            idx_d   = '0;
            tri_d   = '0;
            phase_d = PH_FLAT;
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        if ((idx_q < fill_q) && (tri_q < TW'(MAX_TRIANGLES))) begin
          rd_en   = 1'b1;
          rd_addr = cx;
          state_d = ST_EVAL_A;
        end else begin
          state_d = ST_COUNT;
        end
      end

      ST_EVAL_A: begin
        cur_y_d = cy;
        state_d = ST_READ;
        idx_d   = idx_q + CW'(1);
        if (idx_q == '0) begin
          // first entry seeds all three points
          left_x_d  = cx;
          left_y_d  = cy;
          peak_x_d  = cx;
          peak_y_d  = cy;
          right_x_d = cx;
          right_y_d = cy;
        end else begin
          unique case (phase_q)
            PH_RISE: begin
              if (!cmp.gt) begin
                peak_x_d  = cx;
                peak_y_d  = cy;
                right_x_d = cx;
                right_y_d = cy;
              end else begin
                drop_ge_d = cmp.ge_th;
                idx_d     = idx_q;
                state_d   = ST_EVAL_B;
              end
            end
            PH_FALL: begin
              if (cmp.ge) begin
                // right bottom reached, walk back from the peak
                walk_d  = peak_x_q;
                below_d = 1'b0;
                idx_d   = idx_q;
                state_d = ST_WALK_RD;
              end else begin
                right_x_d = cx;
                right_y_d = cy;
              end
            end
            default: begin
              if (!cmp.gt) begin
                left_x_d  = cx;
                left_y_d  = cy;
                peak_x_d  = cx;
                peak_y_d  = cy;
                right_x_d = cx;
                right_y_d = cy;
              end else begin
                phase_d   = PH_RISE;
                peak_x_d  = cx;
                peak_y_d  = cy;
                right_x_d = cx;
                right_y_d = cy;
              end
            end
          endcase
        end
      end

      ST_EVAL_B: begin
        state_d = ST_READ;
        idx_d   = idx_q + CW'(1);
        if (cmp.gt) begin
          if (drop_ge_q) begin
            phase_d = PH_FALL;
          end
          right_x_d = cx;
          right_y_d = cur_y_q;
        end else if (drop_ge_q) begin
          idx_d   = idx_q;
          state_d = ST_EVAL_C;
        end else begin
          phase_d   = PH_FLAT;
          left_x_d  = cx;
          left_y_d  = cur_y_q;
          peak_x_d  = cx;
          peak_y_d  = cur_y_q;
          right_x_d = cx;
          right_y_d = cur_y_q;
        end
      end

      ST_EVAL_C: begin
        state_d = ST_READ;
        idx_d   = idx_q + CW'(1);
        if (cmp.ge_th) begin
          phase_d = PH_FALL;
        end else begin
          phase_d   = PH_FLAT;
          left_x_d  = cx;
          left_y_d  = cur_y_q;
          peak_x_d  = cx;
          peak_y_d  = cur_y_q;
          right_x_d = cx;
          right_y_d = cur_y_q;
        end
      end

      ST_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = walk_q;
        state_d = ST_WALK_EV;
      end

      ST_WALK_EV: begin
        if (below_q && cmp.ge) begin
          // base is the entry just above this one
          base_x_d = walk_q + AW'(1);
          base_y_d = prev_q;
          state_d  = ST_EMIT;
        end else begin
          if (!below_q && cmp.ge_th) begin
            below_d = 1'b1;
          end
          prev_d = rd_data;
          if (walk_q == '0) begin
            // no base found, drop this triangle
            phase_d   = PH_FLAT;
            left_x_d  = cx;
            left_y_d  = cur_y_q;
            peak_x_d  = cx;
            peak_y_d  = cur_y_q;
            right_x_d = cx;
            right_y_d = cur_y_q;
            idx_d     = idx_q + CW'(1);
            state_d   = ST_READ;
          end else begin
            walk_d  = walk_q - AW'(1);
            state_d = ST_WALK_RD;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_q) begin
          out_d             = '0;
          out_d.left_x      = XW'(base_x_q);
          out_d.left_y      = base_y_q;
          out_d.peak_x      = XW'(peak_x_q);
          out_d.peak_y      = peak_y_q;
          out_d.right_x     = XW'(right_x_q);
          out_d.right_y     = right_y_q;
          out_valid_d       = 1'b1;
          tri_d             = tri_q + TW'(1);
          phase_d           = PH_FLAT;
          left_x_d          = cx;
          left_y_d          = cur_y_q;
          peak_x_d          = cx;
          peak_y_d          = cur_y_q;
          right_x_d         = cx;
          right_y_d         = cur_y_q;
          idx_d             = idx_q + CW'(1);
          state_d           = ST_READ;
        end
      end

      ST_COUNT: begin
        if (!out_valid_q) begin
          out_d             = '0;
          out_d.is_count    = 1'b1;
          out_d.found_count = CountW'(tri_q);
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          fill_d            = '0;
          state_d           = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      phase_q     <= PH_FLAT;
      fill_q      <= '0;
      idx_q       <= '0;
      tri_q       <= '0;
      below_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      tri_q       <= tri_d;
      below_q     <= below_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    th_q      <= th_d;
    left_x_q  <= left_x_d;
    left_y_q  <= left_y_d;
    peak_x_q  <= peak_x_d;
    peak_y_q  <= peak_y_d;
    right_x_q <= right_x_d;
    right_y_q <= right_y_d;
    cur_y_q   <= cur_y_d;
    drop_ge_q <= drop_ge_d;
    walk_q    <= walk_d;
    prev_q    <= prev_d;
    base_x_q  <= base_x_d;
    base_y_q  <= base_y_d;
    out_q     <= out_d;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_scan_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (idx_q <= fill_q))
    else $error("scan index beyond filled entries");

  a_tri_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_q <= TW'(MAX_TRIANGLES))
    else $error("triangle count beyond limit");

  a_walk_below_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_RD || state_q == ST_WALK_EV) |-> (walk_q <= peak_x_q))
    else $error("base walk above the peak");

  a_count_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COUNT && !out_valid_q) |=> (out_valid_q && out_q.last && in_ready_o))
    else $error("count word not issued at scan end");
`endif

endmodule
`default_nettype wire
